// ----- hdl/lphm_pkg.sv -----
// ---------------------------------------------------------------------------
// lphm_pkg: shared types and constants for the linear probing hash map
// Sizes, memory word layouts, command and status codes and controller states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lphm_pkg;

    localparam int SLOTS      = 256;
    localparam int ITEMS      = 128;
    localparam int VALUE_BITS = 32;

    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int ITEM_BITS  = $clog2(ITEMS);
    localparam int CNT_BITS   = $clog2(ITEMS + 1);
    localparam int HC_BITS    = SLOT_BITS + 1;
    localparam int FILL_LIMIT = SLOTS - SLOTS / 3;

    localparam int KEY_BITS   = 64;
    localparam int HASH_BITS  = 32;

    typedef enum logic [1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_NOT_FOUND = 3'd1,
        STS_DUPLICATE = 3'd2,
        STS_FULL      = 3'd3,
        STS_ZERO_HASH = 3'd4
    } status_t;

    typedef struct packed {
        logic [HASH_BITS-1:0] hash;
        logic [ITEM_BITS-1:0] idx;
        logic [HC_BITS-1:0]   hc;
    } slot_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [SLOT_BITS-1:0]  slot;
    } item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_HASH,
        ST_LOC_HOME,
        ST_LOC_RD,
        ST_LOC_CHK,
        ST_LOC_KEY,
        ST_DECIDE,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_WR,
        ST_RM_WR,
        ST_HC_RD,
        ST_HC_WR,
        ST_MV_RD,
        ST_MV_WR,
        ST_MV_SLOT,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/lphm_hash.sv -----
// ---------------------------------------------------------------------------
// lphm_hash: three-stage pipelined 64-to-32-bit integer mix hash
// One wide add or shift-add group per stage; done flags a valid result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lphm_hash (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [lphm_pkg::KEY_BITS-1:0] key,
    output logic                               done,
    output logic [lphm_pkg::HASH_BITS-1:0]     hash
);
    import lphm_pkg::*;

    logic [KEY_BITS-1:0]  k1_next, k2_next, k3_next;
    logic [KEY_BITS-1:0]  st1_reg, st2_reg;
    logic [KEY_BITS-1:0]  k4, k5, k6;
    logic [HASH_BITS-1:0] hash_reg;
    logic [2:0]           vld_reg;

    always_comb begin
        k1_next = (~key) + (key << 18);
        k2_next = k1_next ^ (k1_next >> 31);
        k3_next = (st1_reg << 4) + (st1_reg << 2) + st1_reg;
        k4      = st2_reg ^ (st2_reg >> 11);
        k5      = k4 + (k4 << 6);
        k6      = k5 ^ (k5 >> 22);
    end

    always_ff @(posedge aclk) begin
        st1_reg  <= k2_next;
        st2_reg  <= k3_next;
        hash_reg <= k6[HASH_BITS-1:0];
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[1:0], start};
        end
    end

    assign done = vld_reg[2];
    assign hash = hash_reg;

endmodule

`default_nettype wire

// ----- hdl/lphm_slot_mem.sv -----
// ---------------------------------------------------------------------------
// lphm_slot_mem: slot table memory with per-entry valid bits
// One access per cycle, registered read data. An entry that is not valid
// reads as an empty slot with a zero home count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lphm_slot_mem (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           clear,
    input  wire logic [lphm_pkg::SLOT_BITS-1:0] addr,
    input  wire logic                           wr_en,
    input  wire lphm_pkg::slot_t                wdata,
    output lphm_pkg::slot_t                     rdata
);
    import lphm_pkg::*;

    slot_t      mem [SLOTS];
    logic       valid_reg [SLOTS];
    slot_t      data_reg;
    logic       hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end
        data_reg <= mem[addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            for (int i = 0; i < SLOTS; i++) begin
                valid_reg[i] <= 1'b0;
            end
            hit_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[addr] <= 1'b1;
            end
            hit_reg <= valid_reg[addr];
        end
    end

    always_comb begin
        rdata = data_reg;
        if (!hit_reg) begin
            rdata.hash = '0;
            rdata.hc   = '0;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/lphm_item_mem.sv -----
// ---------------------------------------------------------------------------
// lphm_item_mem: dense item array memory
// Key, value and owning slot per item; one access per cycle, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lphm_item_mem (
    input  wire logic                           aclk,
    input  wire logic [lphm_pkg::ITEM_BITS-1:0] addr,
    input  wire logic                           wr_en,
    input  wire lphm_pkg::item_t                wdata,
    output lphm_pkg::item_t                     rdata
);
    import lphm_pkg::*;

    item_t mem [ITEMS];
    item_t data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end
        data_reg <= mem[addr];
    end

    assign rdata = data_reg;

endmodule

`default_nettype wire

// ----- hdl/linear_probe_hash_map_top.sv -----
// ---------------------------------------------------------------------------
// linear_probe_hash_map_top: fixed-capacity hash map with linear probing
// Find, insert, remove and clear requests on a stream, one result per request.
// ---------------------------------------------------------------------------
// One request is handled at a time, from its acceptance until its result
// is registered for the output. A clear goes straight to the result. Other
// requests hash the key and read the home slot's count, then probe slots in
// turn, with a key compare on each hash match, until the key is found or
// no slot of that home is left. An insert then searches from the home slot
// for a free place and writes back, and a remove writes back and moves the
// last item into the freed place. The pace is set by the single-port slot
// memory, which every probe reads in turn. Slots are emptied by valid bits,
// so reset and clear take effect at once, with no sweep. A new request is
// taken while the previous result still waits on the output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_map_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // key[63:0], value[95:64]
    input  wire logic [1:0]   s_tuser,   // kind[1:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [47:0]       m_tdata    // status[2:0], value_out[34:3], entry_count[42:35]
);
    import lphm_pkg::*;

    state_t                state_reg, state_next;
    cmd_t                  kind_reg, kind_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [HASH_BITS-1:0]  h_reg, h_next;
    logic [SLOT_BITS-1:0]  home_reg, home_next;
    logic [SLOT_BITS-1:0]  s_reg, s_next;
    logic [HC_BITS-1:0]    left_reg, left_next;
    logic                  found_reg, found_next;
    slot_t                 slot_reg, slot_next;
    item_t                 item_reg, item_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [SLOT_BITS-1:0]  mv_slot_reg, mv_slot_next;
    status_t               sts_reg, sts_next;
    logic [31:0]           vout_reg, vout_next;
    logic                  out_vld_reg, out_vld_next;
    status_t               out_sts_reg, out_sts_next;
    logic [31:0]           out_val_reg, out_val_next;
    logic [7:0]            out_cnt_reg, out_cnt_next;

    logic                  accept;
    logic                  hash_start, hash_done;
    logic [HASH_BITS-1:0]  hash_val;
    logic                  slot_clear, slot_we;
    logic [SLOT_BITS-1:0]  slot_addr;
    slot_t                 slot_wdata, slot_rdata;
    logic                  item_we;
    logic [ITEM_BITS-1:0]  item_addr;
    item_t                 item_wdata, item_rdata;
    logic [CNT_BITS-1:0]   last;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign last     = count_reg - CNT_BITS'(1);

    lphm_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (key_reg),
        .done    (hash_done),
        .hash    (hash_val)
    );

    lphm_slot_mem u_slot_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (slot_clear),
        .addr    (slot_addr),
        .wr_en   (slot_we),
        .wdata   (slot_wdata),
        .rdata   (slot_rdata)
    );

    lphm_item_mem u_item_mem (
        .aclk    (aclk),
        .addr    (item_addr),
        .wr_en   (item_we),
        .wdata   (item_wdata),
        .rdata   (item_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        h_next       = h_reg;
        home_next    = home_reg;
        s_next       = s_reg;
        left_next    = left_reg;
        found_next   = found_reg;
        slot_next    = slot_reg;
        item_next    = item_reg;
        count_next   = count_reg;
        mv_slot_next = mv_slot_reg;
        sts_next     = sts_reg;
        vout_next    = vout_reg;
        out_vld_next = out_vld_reg;
        out_sts_next = out_sts_reg;
        out_val_next = out_val_reg;
        out_cnt_next = out_cnt_reg;
        hash_start   = 1'b0;
        slot_clear   = 1'b0;
        slot_we      = 1'b0;
        slot_addr    = s_reg;
        slot_wdata   = slot_reg;
        item_we      = 1'b0;
        item_addr    = slot_reg.idx;
        item_wdata   = item_reg;

        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next  = cmd_t'(s_tuser);
                    key_next   = s_tdata[63:0];
                    val_next   = VALUE_BITS'(s_tdata[95:64]);
                    sts_next   = STS_OK;
                    vout_next  = '0;
                    found_next = 1'b0;
                    if (cmd_t'(s_tuser) == CMD_CLEAR) begin
                        slot_clear = 1'b1;
                        count_next = '0;
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                hash_start = !hash_done;
                if (hash_done) begin
                    h_next     = hash_val;
                    home_next  = hash_val[SLOT_BITS-1:0];
                    s_next     = hash_val[SLOT_BITS-1:0];
                    slot_addr  = hash_val[SLOT_BITS-1:0];
                    state_next = ST_LOC_HOME;
                end
            end
            ST_LOC_HOME: begin
                left_next  = slot_rdata.hc;
                state_next = ST_LOC_RD;
            end
            ST_LOC_RD: begin
                if (left_reg == '0) begin
                    state_next = ST_DECIDE;
                end else begin
                    slot_addr  = s_reg;
                    state_next = ST_LOC_CHK;
                end
            end
            ST_LOC_CHK: begin
                s_next     = s_reg + SLOT_BITS'(1);
                state_next = ST_LOC_RD;
                if (slot_rdata.hash != '0 && slot_rdata.hash[SLOT_BITS-1:0] == home_reg) begin
                    left_next = left_reg - HC_BITS'(1);
                    if (slot_rdata.hash == h_reg && int'(slot_rdata.idx) < ITEMS) begin
                        slot_next  = slot_rdata;
                        item_addr  = slot_rdata.idx;
                        s_next     = s_reg;
                        state_next = ST_LOC_KEY;
                    end
                end
            end
            ST_LOC_KEY: begin
                if (item_rdata.key == key_reg) begin
                    found_next = 1'b1;
                    item_next  = item_rdata;
                    state_next = ST_DECIDE;
                end else begin
                    s_next     = s_reg + SLOT_BITS'(1);
                    state_next = ST_LOC_RD;
                end
            end
            ST_DECIDE: begin
                state_next = ST_RESP;
                case (kind_reg)
                    CMD_FIND: begin
                        if (found_reg) begin
                            vout_next = 32'(item_reg.value);
                        end else begin
                            sts_next = STS_NOT_FOUND;
                        end
                    end
                    CMD_INSERT: begin
                        if (found_reg) begin
                            sts_next = STS_DUPLICATE;
                        end else if (int'(count_reg) >= ITEMS
                                     || int'(count_reg) >= FILL_LIMIT) begin
                            sts_next = STS_FULL;
                        end else if (h_reg == '0) begin
                            sts_next = STS_ZERO_HASH;
                        end else begin
                            s_next     = home_reg;
                            state_next = ST_INS_RD;
                        end
                    end
                    CMD_REMOVE: begin
                        if (!found_reg || count_reg == '0) begin
                            sts_next = STS_NOT_FOUND;
                        end else begin
                            state_next = ST_RM_WR;
                        end
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_INS_RD: begin
                slot_addr  = s_reg;
                state_next = ST_INS_CHK;
            end
            ST_INS_CHK: begin
                if (slot_rdata.hash == '0) begin
                    slot_next  = slot_rdata;
                    state_next = ST_INS_WR;
                end else begin
                    s_next     = s_reg + SLOT_BITS'(1);
                    state_next = ST_INS_RD;
                end
            end
            ST_INS_WR: begin
                slot_we          = 1'b1;
                slot_addr        = s_reg;
                slot_wdata.hash  = h_reg;
                slot_wdata.idx   = ITEM_BITS'(count_reg);
                slot_wdata.hc    = slot_reg.hc;
                item_we          = 1'b1;
                item_addr        = ITEM_BITS'(count_reg);
                item_wdata.key   = key_reg;
                item_wdata.value = val_reg;
                item_wdata.slot  = s_reg;
                state_next       = ST_HC_RD;
            end
            ST_RM_WR: begin
                slot_we         = 1'b1;
                slot_addr       = s_reg;
                slot_wdata      = slot_reg;
                slot_wdata.hash = '0;
                state_next      = ST_HC_RD;
            end
            ST_HC_RD: begin
                slot_addr  = home_reg;
                state_next = ST_HC_WR;
            end
            ST_HC_WR: begin
                slot_we    = 1'b1;
                slot_addr  = home_reg;
                slot_wdata = slot_rdata;
                if (kind_reg == CMD_INSERT) begin
                    slot_wdata.hc = slot_rdata.hc + HC_BITS'(1);
                    count_next    = count_reg + CNT_BITS'(1);
                    state_next    = ST_RESP;
                end else begin
                    if (slot_rdata.hc != '0) begin
                        slot_wdata.hc = slot_rdata.hc - HC_BITS'(1);
                    end
                    if (CNT_BITS'(slot_reg.idx) != last && int'(last) < ITEMS) begin
                        state_next = ST_MV_RD;
                    end else begin
                        count_next = last;
                        state_next = ST_RESP;
                    end
                end
            end
            ST_MV_RD: begin
                item_addr  = ITEM_BITS'(last);
                state_next = ST_MV_WR;
            end
            ST_MV_WR: begin
                item_we      = 1'b1;
                item_addr    = slot_reg.idx;
                item_wdata   = item_rdata;
                slot_addr    = item_rdata.slot;
                mv_slot_next = item_rdata.slot;
                state_next   = ST_MV_SLOT;
            end
            ST_MV_SLOT: begin
                slot_we        = 1'b1;
                slot_addr      = mv_slot_reg;
                slot_wdata     = slot_rdata;
                slot_wdata.idx = slot_reg.idx;
                count_next     = last;
                state_next     = ST_RESP;
            end
            ST_RESP: begin
                if (!out_vld_reg || m_tready) begin
                    out_vld_next = 1'b1;
                    out_sts_next = sts_reg;
                    out_val_next = vout_reg;
                    out_cnt_next = 8'(count_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            out_vld_reg <= out_vld_next;
        end
        kind_reg    <= kind_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        h_reg       <= h_next;
        home_reg    <= home_next;
        s_reg       <= s_next;
        left_reg    <= left_next;
        found_reg   <= found_next;
        slot_reg    <= slot_next;
        item_reg    <= item_next;
        mv_slot_reg <= mv_slot_next;
        sts_reg     <= sts_next;
        vout_reg    <= vout_next;
        out_sts_reg <= out_sts_next;
        out_val_reg <= out_val_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, out_cnt_reg, out_val_reg, out_sts_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= ITEMS && int'(count_reg) <= FILL_LIMIT)
        else $error("stored entry count exceeds capacity");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd_t'(s_tuser) == CMD_CLEAR |=> count_reg == '0)
        else $error("clear did not empty the map");

    a_miss_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_sts_reg != STS_OK |-> out_val_reg == '0)
        else $error("failed request returned a value");

endmodule

`default_nettype wire
